FILE: hdl/sdec_pkg.sv
`timescale 1ns / 1ps

package sdec_pkg;

    // Fixed widths of the register file and of the result fields
    localparam int ROW_W      = 16;
    localparam int NUM_ROWS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int WORD_W     = 16;
    localparam int SYN_W      = 8;
    localparam int FLIPS_W    = 2;
    localparam int POS_W      = 4;
    localparam int OUT_DATA_W = 40;

    // Number of flipped bits
    localparam logic [FLIPS_W-1:0] FLIPS_NONE = 2'd0;
    localparam logic [FLIPS_W-1:0] FLIPS_ONE  = 2'd1;
    localparam logic [FLIPS_W-1:0] FLIPS_TWO  = 2'd2;

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] t_hmat;

    typedef struct packed {
        logic               uncorrectable;
        logic [POS_W-1:0]   second_position;
        logic [POS_W-1:0]   first_position;
        logic [FLIPS_W-1:0] flips_done;
        logic               word_ok;
        logic [SYN_W-1:0]   syndrome;
        logic [WORD_W-1:0]  corrected_word;
    } t_result;

endpackage

FILE: hdl/sdec_regs.sv
`timescale 1ns / 1ps

module sdec_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sdec_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdec_pkg::ROW_W-1:0]     i_cfg_data,
    output sdec_pkg::t_hmat                o_h
);
    import sdec_pkg::*;

    t_hmat r_h;

    assign o_cfg_ready = 1'b1;
    assign o_h         = r_h;

    // Writes to an index past the last row are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_ROWS))) begin
            r_h[i_cfg_index[$clog2(NUM_ROWS)-1:0]] <= i_cfg_data;
        end
    end

endmodule

FILE: hdl/sdec_decode.sv
`timescale 1ns / 1ps

module sdec_decode #(
    parameter int CODE_BITS  = 16,
    parameter int CHECK_BITS = 8
) (
    input  logic [sdec_pkg::WORD_W-1:0] i_word,
    input  sdec_pkg::t_hmat             i_h,
    output sdec_pkg::t_result           o_res
);
    import sdec_pkg::*;

    localparam int DATA_BITS = CODE_BITS - CHECK_BITS;

    logic [CODE_BITS-1:0]                 word_ext;
    logic [CODE_BITS-1:0][CHECK_BITS-1:0] cols;
    logic [CHECK_BITS-1:0]                syn;
    logic                                 acc;
    logic                                 single_hit;
    logic                                 pair_hit;
    logic [CODE_BITS-1:0]                 single_mask;
    logic [CODE_BITS-1:0]                 pair_mask;
    logic [POS_W-1:0]                     single_pos;
    logic [POS_W-1:0]                     pair_pos1;
    logic [POS_W-1:0]                     pair_pos2;
    logic [CODE_BITS-1:0]                 fixed;

    // Word at code width; columns of H (register bits past ROW_W read as zero)
    always_comb begin
        for (int k = 0; k < CODE_BITS; k++) begin
            word_ext[k] = (k < WORD_W) ? i_word[k] : 1'b0;
        end
        for (int c = 0; c < CODE_BITS; c++) begin
            for (int r = 0; r < CHECK_BITS; r++) begin
                cols[c][r] = (c < ROW_W) ? i_h[r][c] : 1'b0;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < CHECK_BITS; r++) begin
            acc = word_ext[DATA_BITS + r];
            for (int c = 0; c < DATA_BITS; c++) begin
                acc = acc ^ (word_ext[c] & cols[c][r]);
            end
            syn[r] = acc;
        end
    end

    // Priority search: scan downwards so that the lowest match is written last
    always_comb begin
        single_hit  = 1'b0;
        single_mask = '0;
        single_pos  = '0;
        for (int i = CODE_BITS - 1; i >= 0; i--) begin
            if (cols[i] == syn) begin
                single_hit  = 1'b1;
                single_mask = '0;
                single_mask[i] = 1'b1;
                single_pos  = POS_W'(i);
            end
        end
    end

    always_comb begin
        pair_hit  = 1'b0;
        pair_mask = '0;
        pair_pos1 = '0;
        pair_pos2 = '0;
        for (int i = CODE_BITS - 2; i >= 0; i--) begin
            for (int j = CODE_BITS - 1; j > i; j--) begin
                if ((cols[i] ^ cols[j]) == syn) begin
                    pair_hit  = 1'b1;
                    pair_mask = '0;
                    pair_mask[i] = 1'b1;
                    pair_mask[j] = 1'b1;
                    pair_pos1 = POS_W'(i);
                    pair_pos2 = POS_W'(j);
                end
            end
        end
    end

    always_comb begin
        o_res          = '0;
        o_res.syndrome = SYN_W'(syn);
        fixed          = word_ext;
        if (syn == '0) begin
            o_res.word_ok = 1'b1;
        end else if (single_hit) begin
            fixed                = word_ext ^ single_mask;
            o_res.flips_done     = FLIPS_ONE;
            o_res.first_position = single_pos;
        end else if (pair_hit) begin
            fixed                 = word_ext ^ pair_mask;
            o_res.flips_done      = FLIPS_TWO;
            o_res.first_position  = pair_pos1;
            o_res.second_position = pair_pos2;
        end else begin
            o_res.flips_done    = FLIPS_NONE;
            o_res.uncorrectable = 1'b1;
        end
        for (int k = 0; k < WORD_W; k++) begin
            o_res.corrected_word[k] = (k < CODE_BITS) ? fixed[k] : 1'b0;
        end
    end

endmodule

FILE: hdl/syndrome_double_error_corrector.sv
`timescale 1ns / 1ps
// Syndrome decoder for a linear block code that corrects up to two bit errors.
// Channels:
//   cfg    - write channel (i_cfg_valid / o_cfg_ready, index and data) that loads
//            the eight parity-check rows; always ready. Write only while idle.
//   s_axis - received codewords, one per transaction in s_axis_tdata[15:0].
//   m_axis - one result per codeword: corrected word, syndrome and status.
// Pipeline: the input register, then one pass of syndrome and search logic into
// the result register. Throughput: one codeword per cycle while the receiver
// keeps m_axis_tready high, set by the single registered pass of decode logic.
// Back-pressure: when the receiver holds m_axis_tready low the result register
// holds its transaction, the input register fills and s_axis_tready drops; no
// transaction is lost or repeated.
// Reset (synchronous, active low): clears both pipeline valid bits and all
// parity-check rows to zero; with a zero matrix any nonzero syndrome reports
// the word as uncorrectable.

module syndrome_double_error_corrector #(
    parameter int CODE_BITS  = 16,
    parameter int CHECK_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sdec_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sdec_pkg::ROW_W-1:0]          i_cfg_data,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sdec_pkg::WORD_W-1:0]         s_axis_tdata,  // [15:0] received_word
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] corrected_word, [23:16] syndrome, [24] word_ok, [26:25] flips_done,
    // [30:27] first_position, [34:31] second_position, [35] uncorrectable,
    // [39:36] zero
    output logic [sdec_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import sdec_pkg::*;

    t_hmat                h;
    t_result              dec_res;
    logic                 advance;

    logic                 r_in_valid;
    logic [WORD_W-1:0]    r_in_word;
    logic                 r_out_valid;
    t_result              r_out_res;

    sdec_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_h         (h)
    );

    sdec_decode #(
        .CODE_BITS  (CODE_BITS),
        .CHECK_BITS (CHECK_BITS)
    ) u_decode (
        .i_word (r_in_word),
        .i_h    (h),
        .o_res  (dec_res)
    );

    // Advance the pipeline whenever the result register is empty or being taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_word <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_res <= dec_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_res);

endmodule
